FILE: rtl/core/ist_pkg.sv
package ist_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	// index with one extra bit: set for the two out-of-range probes (depth and minus one)
	localparam int AIDX_W      = IDX_W + 1;
	localparam int DATA_W      = 32;
	localparam int CNT_W       = 11;
	localparam int PROD_W      = IDX_W + DATA_W;
	localparam int STEP_W      = $clog2(IDX_W);
	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;

	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_SEARCH = 1'b1;

	localparam logic [PADDR_W-3:0] REG_ENTRY_COUNT = '0;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_LO,
		ST_RD_HI,
		ST_CHECK,
		ST_MUL,
		ST_DIV,
		ST_RD_EST,
		ST_CMP,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

FILE: rtl/core/ist_if.sv
interface ist_in_if import ist_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     command;
	logic [IDX_W-1:0]         index;
	logic signed [DATA_W-1:0] value;

	modport source (output valid, command, index, value, input ready);
	modport sink (input valid, command, index, value, output ready);
endinterface

interface ist_out_if import ist_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             found;
	logic [IDX_W-1:0] position;

	modport source (output valid, found, position, input ready);
	modport sink (input valid, found, position, output ready);
endinterface

FILE: rtl/core/ist_div.sv
module ist_div import ist_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [PROD_W-1:0] dividend,
	input  logic [DATA_W-1:0] divisor,
	output div_stat_t         stat,
	output logic [IDX_W-1:0]  quotient
);

	// restoring division; the quotient is known to fit IDX_W bits
	logic [PROD_W-1:0] rem_q;
	logic [PROD_W-1:0] den_sh_q;
	logic [IDX_W-1:0]  quo_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic              ge;

	assign ge = (rem_q >= den_sh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(IDX_W - 1);
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q    <= dividend;
			den_sh_q <= PROD_W'(divisor) << (IDX_W - 1);
			quo_q    <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - den_sh_q;
			end
			den_sh_q <= den_sh_q >> 1;
			quo_q    <= {quo_q[IDX_W-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule

FILE: rtl/core/interpolation_search_table.sv
// Interpolation search over a sorted table of 1024 signed 32-bit entries held in one
// single-port-read, single-port-write synchronous RAM. A write item stores one entry and
// yields no result. A search item yields one result (found flag and position). It reads
// and checks the bounds (ST_RD_LO, ST_RD_HI, ST_CHECK), runs its interpolation probes
// and then loads the output register. Each probe starts the divider, waits for the
// 10-step restoring divider that forms the estimate, reads and compares the estimate
// and rereads the narrowed bounds; a probe that hits the key skips the reread. A count
// of zero answers not found without reading the table. A finished search holds while
// the output register still waits for its transfer. Only one search is in flight at a
// time; the next item is taken as soon as the previous result sits in the output
// register, even if that result has not yet been transferred. entry_count lives at
// byte address 0 of the APB port and saturates at the table depth when searching.
module interpolation_search_table import ist_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	ist_in_if.sink             search,
	ist_out_if.source          result
);

	state_t state_q, state_d;

	logic [CNT_W-1:0] count_q;

	// table RAM
	logic [DATA_W-1:0] mem [TABLE_DEPTH];
	logic [DATA_W-1:0] rdata_q;
	logic              rd_oor_q;
	logic [AIDX_W-1:0] rd_addr;
	logic              mem_we;
	logic signed [DATA_W-1:0] rd_val;

	// search working registers
	logic signed [DATA_W-1:0] key_q;
	logic signed [DATA_W-1:0] vl_q;
	logic [AIDX_W-1:0]        lo_q;
	logic [AIDX_W-1:0]        hi_q;
	logic [IDX_W-1:0]         est_q;
	logic [IDX_W-1:0]         span_q;
	logic [DATA_W-1:0]        num_q;
	logic [DATA_W-1:0]        den_q;
	logic                     res_found_q;
	logic [IDX_W-1:0]         res_pos_q;

	// output register
	logic             out_valid_q;
	logic             out_found_q;
	logic [IDX_W-1:0] out_pos_q;

	logic              in_xfer;
	logic              cfg_we;
	logic              lo_le_hi;
	logic              probe_go;
	logic              out_free;
	logic [AIDX_W-1:0] n_m1;
	logic              div_start;
	div_stat_t         div_stat;
	logic [IDX_W-1:0]  div_quo;
	logic [PROD_W-1:0] prod;

	// ---------------------------------------------------------------- config port
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready
		&& (paddr[PADDR_W-1:2] == REG_ENTRY_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_we) begin
			count_q <= pwdata[CNT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[PADDR_W-1:2] == REG_ENTRY_COUNT) begin
			prdata = PDATA_W'(count_q);
		end
	end

	// ---------------------------------------------------------------- table RAM
	// Writes are taken only while idle, so no read of the same entry can overlap.
	assign search.ready = (state_q == ST_IDLE);
	assign in_xfer      = search.valid && search.ready;
	assign mem_we       = in_xfer && (search.command == CMD_WRITE);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[search.index] <= search.value;
		end
		rdata_q  <= mem[rd_addr[IDX_W-1:0]];
		rd_oor_q <= rd_addr[IDX_W];
	end

	// a probe outside the table reads as zero
	assign rd_val = rd_oor_q ? '0 : $signed(rdata_q);

	// ---------------------------------------------------------------- estimate divider
	assign prod = PROD_W'(span_q) * PROD_W'(num_q);

	ist_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod),
		.divisor  (den_q),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	// ---------------------------------------------------------------- control
	assign n_m1 = (count_q > CNT_W'(TABLE_DEPTH)) ? AIDX_W'(TABLE_DEPTH - 1)
		: AIDX_W'(count_q - 1'b1);

	// bounds compared as signed: hi may have dropped to minus one
	assign lo_le_hi = $signed({1'b0, lo_q}) <= $signed({hi_q[AIDX_W-1], hi_q});
	// rd_val holds the high-bound entry while in ST_CHECK
	assign probe_go = lo_le_hi && (vl_q < key_q) && (rd_val > key_q);
	assign out_free = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		rd_addr   = lo_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer && (search.command == CMD_SEARCH)) begin
					state_d = (count_q == '0) ? ST_OUT : ST_RD_LO;
				end
			end
			ST_RD_LO: begin
				rd_addr = lo_q;
				state_d = ST_RD_HI;
			end
			ST_RD_HI: begin
				rd_addr = hi_q;
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				state_d = probe_go ? ST_MUL : ST_OUT;
			end
			ST_MUL: begin
				div_start = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				if (div_stat.done) begin
					state_d = ST_RD_EST;
				end
			end
			ST_RD_EST: begin
				rd_addr = {1'b0, est_q};
				state_d = ST_CMP;
			end
			ST_CMP: begin
				state_d = (rd_val == key_q) ? ST_OUT : ST_RD_LO;
			end
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// ---------------------------------------------------------------- datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				key_q       <= search.value;
				lo_q        <= '0;
				hi_q        <= n_m1;
				res_found_q <= 1'b0;
				res_pos_q   <= '0;
			end
			ST_RD_HI: begin
				vl_q <= rd_val;
			end
			ST_CHECK: begin
				// differences are positive and below 2^32 when the probe goes ahead
				span_q <= hi_q[IDX_W-1:0] - lo_q[IDX_W-1:0];
				num_q  <= key_q - vl_q;
				den_q  <= rd_val - vl_q;
				if (!probe_go) begin
					if (vl_q == key_q) begin
						res_found_q <= 1'b1;
						res_pos_q   <= lo_q[IDX_W-1:0];
					end else if (rd_val == key_q) begin
						res_found_q <= 1'b1;
						res_pos_q   <= hi_q[IDX_W-1:0];
					end
				end
			end
			ST_DIV: begin
				if (div_stat.done) begin
					est_q <= lo_q[IDX_W-1:0] + div_quo;
				end
			end
			ST_CMP: begin
				if (key_q < rd_val) begin
					hi_q <= AIDX_W'({1'b0, est_q}) - AIDX_W'(1);
				end else if (key_q > rd_val) begin
					lo_q <= AIDX_W'({1'b0, est_q}) + AIDX_W'(1);
				end else begin
					res_found_q <= 1'b1;
					res_pos_q   <= est_q;
				end
			end
			default: begin
			end
		endcase
	end

	// ---------------------------------------------------------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_OUT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_OUT) && out_free) begin
			out_found_q <= res_found_q;
			out_pos_q   <= res_pos_q;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.found    = out_found_q;
	assign result.position = out_pos_q;

	// ---------------------------------------------------------------- assertions
	// never restart the divider while it is still iterating
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider started while busy");

	// the estimate must lie in [lo, hi) of the current bounds
	a_est_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD_EST) |->
		(({1'b0, est_q} >= lo_q) && ($signed({2'b00, est_q}) < $signed({hi_q[AIDX_W-1], hi_q}))))
		else $error("interpolation estimate outside bounds");

	// a finished search always lands in the output register
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_OUT) && out_free) |=> out_valid_q)
		else $error("search result not loaded");

	// table writes only while no search is running
	a_we_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !mem_we)
		else $error("table written during a search");

endmodule

FILE: tb/interpolation_search_table_tb.sv
`timescale 1ns / 100ps

module interpolation_search_table_tb import ist_pkg::*;;

	// Generous ceiling: small unsorted tables can cost one probe per entry.
	localparam int CYCLE_LIMIT   = 5000000;
	// Length of the long receiver hold-off that makes the block back up.
	localparam int HOLD_CYCLES   = 3000;
	// Idle cycles let pass before a register write, so a trailing write item has landed.
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES   = 64;

	localparam logic signed [DATA_W-1:0] MOST_NEG = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] MOST_POS = 32'sh7fff_ffff;
	localparam logic [PADDR_W-1:0]       COUNT_ADDR = {REG_ENTRY_COUNT, 2'b00};

	// Ways of loading the table at the start of a phase.
	localparam int FILL_SPREAD  = 0; // wide, roughly even steps
	localparam int FILL_DENSE   = 1; // tiny steps, many duplicates
	localparam int FILL_EXTREME = 2; // most negative and most positive at the ends
	localparam int FILL_NONE    = 3; // keep what is there

	localparam int NUM_PHASES = 8;
	localparam int PHASE_COUNT [NUM_PHASES] = '{1, 2, 16, 64, 7, 0, 120, 33};
	localparam int PHASE_ITEMS [NUM_PHASES] = '{40, 40, 80, 90, 60, 30, 80, 50};
	localparam int PHASE_FILL  [NUM_PHASES] = '{FILL_DENSE, FILL_EXTREME, FILL_SPREAD,
		FILL_EXTREME, FILL_DENSE, FILL_NONE, FILL_SPREAD, FILL_DENSE};
	// Phase in which the receiver holds off for a long stretch.
	localparam int HOLD_PHASE = 2;

	typedef struct {
		logic             found;
		logic [IDX_W-1:0] position;
	} lookup_t;

	// Shadow of the table and the count, with the lookups still owed by the block.
	class search_scoreboard;
		logic signed [DATA_W-1:0] entries [TABLE_DEPTH];
		logic [CNT_W-1:0]         count;
		lookup_t                  owed_lookups [$];
		int                       mismatches;

		function new();
			foreach (entries[i]) entries[i] = '0;
			count = '0;
			mismatches = 0;
		endfunction

		function void set_count(logic [PDATA_W-1:0] v);
			count = v[CNT_W-1:0];
		endfunction

		// Indices outside the table read as zero.
		function longint entry_at(longint i);
			if (i < 0 || i >= TABLE_DEPTH)
				return 0;
			return longint'(entries[i]);
		endfunction

		function lookup_t lookup(longint key);
			lookup_t r;
			longint  n, lo, hi, vl, vh, est, ve;
			r.found    = 1'b0;
			r.position = '0;
			n = (count > TABLE_DEPTH) ? TABLE_DEPTH : longint'(count);
			if (n == 0)
				return r;
			lo = 0;
			hi = n - 1;
			while (lo <= hi && entry_at(lo) < key && entry_at(hi) > key) begin
				vl  = entry_at(lo);
				vh  = entry_at(hi);
				est = lo + ((hi - lo) * (key - vl)) / (vh - vl);
				ve  = entry_at(est);
				if (key < ve) begin
					hi = est - 1;
				end else if (key > ve) begin
					lo = est + 1;
				end else begin
					r.found    = 1'b1;
					r.position = est[IDX_W-1:0];
					return r;
				end
			end
			if (entry_at(lo) == key) begin
				r.found    = 1'b1;
				r.position = lo[IDX_W-1:0];
			end else if (entry_at(hi) == key) begin
				r.found    = 1'b1;
				r.position = hi[IDX_W-1:0];
			end
			return r;
		endfunction

		function void note_transfer(logic cmd, logic [IDX_W-1:0] idx,
				logic signed [DATA_W-1:0] val);
			if (cmd == CMD_WRITE) begin
				if (idx < TABLE_DEPTH)
					entries[idx] = val;
			end else begin
				owed_lookups.push_back(lookup(longint'(val)));
			end
		endfunction

		function void flag(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("MISMATCH: %s", msg);
		endfunction

		function void check_result(logic found, logic [IDX_W-1:0] position);
			lookup_t want;
			if (owed_lookups.size() == 0) begin
				flag($sformatf("result found=%0b position=%0d with no search pending",
					found, position));
				return;
			end
			want = owed_lookups.pop_front();
			if (found !== want.found)
				flag($sformatf("found: expected %0b, got %0b", want.found, found));
			if (position !== want.position)
				flag($sformatf("position: expected %0d, got %0d", want.position, position));
		endfunction

		function int outstanding();
			return owed_lookups.size();
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	ist_in_if  search_if ();
	ist_out_if result_if ();

	interpolation_search_table dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.search  (search_if),
		.result  (result_if)
	);

	search_scoreboard scoreboard = new();

	// Stimulus-side copy of the table, used to pick keys and in-order values.
	logic signed [DATA_W-1:0] shadow [TABLE_DEPTH];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_asked     = 0;
	int cycle_count    = 0;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Abort a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Result side: random stalls, plus the long hold-off when the main flow asks for one.
	initial begin : result_ready_driver
		int hold_served;
		int hold_left;
		hold_served = 0;
		hold_left   = 0;
		result_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				result_if.ready <= 1'b0;
			end else if (hold_left > 0) begin
				result_if.ready <= 1'b0;
				hold_left--;
			end else if (hold_served != hold_asked) begin
				hold_served = hold_asked;
				hold_left   = HOLD_CYCLES;
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Watch both channels. Check the result first: a result and a fresh search can
	// transfer on the same edge, and the result always belongs to an older search.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_if.valid && result_if.ready)
				scoreboard.check_result(result_if.found, result_if.position);
			if (search_if.valid && search_if.ready)
				scoreboard.note_transfer(search_if.command, search_if.index, search_if.value);
		end
	end

	// Offer one item and hold it until the transfer. Keep valid high on return, so the
	// caller either offers the next item or drops valid in this same time step.
	task automatic send_item(input logic cmd, input logic [IDX_W-1:0] idx,
			input logic signed [DATA_W-1:0] val);
		while ($urandom_range(99) < send_idle_pct) begin
			search_if.valid <= 1'b0;
			@(posedge clk);
		end
		search_if.valid   <= 1'b1;
		search_if.command <= cmd;
		search_if.index   <= idx;
		search_if.value   <= val;
		@(posedge clk);
		while (!search_if.ready)
			@(posedge clk);
		if (cmd == CMD_WRITE)
			shadow[idx] = val;
	endtask

	// Drop valid, wait for every owed result, then let a trailing write settle.
	task automatic drain();
		search_if.valid <= 1'b0;
		@(posedge clk);
		while (scoreboard.outstanding() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write entry_count over APB while the block is idle, then read it back.
	task automatic write_count(input logic [PDATA_W-1:0] v);
		logic [PDATA_W-1:0] readback;
		drain();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= COUNT_ADDR;
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		// write lands on this edge; go straight into the read setup
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		readback = prdata;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		scoreboard.set_count(v);
		if (readback !== PDATA_W'(v[CNT_W-1:0]))
			scoreboard.flag($sformatf("entry_count readback: expected %0d, got %0d",
				v[CNT_W-1:0], readback));
	endtask

	// Load entries 0..n-1 in ascending order.
	task automatic fill_table(input int n, input int style);
		longint cur;
		int     step_max;
		logic signed [DATA_W-1:0] val;
		if (style == FILL_SPREAD) begin
			cur      = longint'($urandom_range(1 << 30)) - (longint'(1) << 30);
			step_max = 1 << 20;
		end else begin
			cur      = longint'($urandom_range(2000)) - 1000;
			step_max = (style == FILL_DENSE) ? 3 : 50;
		end
		for (int i = 0; i < n; i++) begin
			if (i > 0)
				cur += longint'($urandom_range(step_max));
			if (cur > MOST_POS)
				cur = MOST_POS;
			val = cur[DATA_W-1:0];
			if (style == FILL_EXTREME && i == 0)
				val = MOST_NEG;
			else if (style == FILL_EXTREME && i == n - 1)
				val = MOST_POS;
			send_item(CMD_WRITE, i[IDX_W-1:0], val);
		end
	endtask

	// Random mix over a table of eff live entries. Most writes keep the order;
	// out-of-order writes land inside the count only for small tables, so the
	// probe count of a search stays bounded.
	task automatic random_items(input int eff, input int n);
		int     pick, idx, sel;
		bit     wrote;
		longint lower, upper, key;
		longint unsigned r, span;
		for (int k = 0; k < n; k++) begin
			pick  = $urandom_range(99);
			wrote = 1'b0;
			if (pick < 35) begin
				if (eff > 0 && $urandom_range(99) < 85) begin
					idx   = $urandom_range(eff - 1);
					lower = (idx > 0) ? longint'(shadow[idx-1]) : longint'(MOST_NEG);
					upper = (idx < eff - 1) ? longint'(shadow[idx+1]) : longint'(MOST_POS);
					if (upper < lower)
						upper = lower;
					r     = {$urandom(), $urandom()};
					span  = upper - lower + 1;
					key   = lower + longint'(r % span);
					send_item(CMD_WRITE, idx[IDX_W-1:0], key[DATA_W-1:0]);
					wrote = 1'b1;
				end else if (eff <= 64) begin
					send_item(CMD_WRITE, IDX_W'($urandom_range(TABLE_DEPTH - 1)), $urandom());
					wrote = 1'b1;
				end else if (eff < TABLE_DEPTH) begin
					// noise, but above the count
					send_item(CMD_WRITE, IDX_W'($urandom_range(TABLE_DEPTH - 1, eff)),
						$urandom());
					wrote = 1'b1;
				end
			end
			if (!wrote) begin
				sel = $urandom_range(99);
				if (eff == 0 || sel < 25) begin
					key = longint'($signed($urandom()));
				end else if (sel < 75) begin
					key = longint'(shadow[$urandom_range(eff - 1)]);
				end else if (sel < 90) begin
					idx = $urandom_range(eff - 1);
					key = longint'(shadow[idx]) + ($urandom_range(1) ? 1 : -1);
					if (key > MOST_POS || key < MOST_NEG)
						key = longint'(shadow[idx]);
				end else begin
					case ($urandom_range(2))
						0: key = MOST_NEG;
						1: key = MOST_POS;
						default: key = 0;
					endcase
				end
				send_item(CMD_SEARCH, IDX_W'($urandom()), key[DATA_W-1:0]);
			end
		end
	endtask

	initial begin : main_flow
		int eff;
		arst_n            <= 1'b0;
		psel              <= 1'b0;
		penable           <= 1'b0;
		pwrite            <= 1'b0;
		paddr             <= '0;
		pwdata            <= '0;
		search_if.valid   <= 1'b0;
		search_if.command <= CMD_WRITE;
		search_if.index   <= '0;
		search_if.value   <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Count of zero straight out of reset: always not found.
		send_item(CMD_SEARCH, '0, 32'sd0);
		send_item(CMD_SEARCH, '1, MOST_POS);

		// Four entries spanning the whole signed range, plus one above the count.
		send_item(CMD_WRITE, 10'd0, MOST_NEG);
		send_item(CMD_WRITE, 10'd1, -32'sd5);
		send_item(CMD_WRITE, 10'd2, 32'sd100);
		send_item(CMD_WRITE, 10'd3, MOST_POS);
		send_item(CMD_WRITE, 10'd1023, 32'sd7);
		write_count(4);
		// Hits at both bounds stress the wide differences; the rest probe the middle.
		send_item(CMD_SEARCH, '0, MOST_NEG);
		send_item(CMD_SEARCH, '0, MOST_POS);
		send_item(CMD_SEARCH, '0, -32'sd5);
		send_item(CMD_SEARCH, '0, 32'sd100);
		send_item(CMD_SEARCH, '0, 32'sd99);
		send_item(CMD_SEARCH, '0, 32'sd7);

		// Out-of-order contents: the search must still end.
		send_item(CMD_WRITE, 10'd0, 32'sd50);
		send_item(CMD_WRITE, 10'd1, 32'sd10);
		send_item(CMD_WRITE, 10'd2, 32'sd40);
		send_item(CMD_WRITE, 10'd3, 32'sd20);
		send_item(CMD_SEARCH, '0, 32'sd30);
		send_item(CMD_SEARCH, '0, 32'sd10);
		send_item(CMD_SEARCH, '0, 32'sd20);

		// Single live entry.
		write_count(1);
		send_item(CMD_SEARCH, '0, 32'sd50);
		send_item(CMD_SEARCH, '0, -32'sd1);

		// Count past the table depth saturates. Keys at or beyond the end entries
		// stop before any probe, so only the first and the last entry are read.
		send_item(CMD_WRITE, 10'd0, -32'sd1000);
		send_item(CMD_WRITE, 10'd1023, 32'sd1000);
		write_count(2047);
		send_item(CMD_SEARCH, '0, -32'sd1000);
		send_item(CMD_SEARCH, '0, 32'sd1000);
		send_item(CMD_SEARCH, '0, -32'sd2000);
		send_item(CMD_SEARCH, '0, 32'sd2000);
		write_count(1025);
		send_item(CMD_SEARCH, '0, 32'sd1000);

		// Random phases: cycle through the idling patterns, vary the count between
		// zero and 120, and reload the table as needed.
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
				default: begin send_idle_pct = 13; recv_stall_pct = 13; end
			endcase
			write_count(PHASE_COUNT[p]);
			eff = (PHASE_COUNT[p] > TABLE_DEPTH) ? TABLE_DEPTH : PHASE_COUNT[p];
			if (PHASE_FILL[p] != FILL_NONE)
				fill_table(eff, PHASE_FILL[p]);
			// Hold off the receiver for a long stretch while items keep coming,
			// so the output register fills and the input stalls.
			if (p == HOLD_PHASE)
				hold_asked++;
			random_items(eff, PHASE_ITEMS[p]);
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (scoreboard.mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
